// ===== src/dsfp_pkg.sv =====
package dsfp_pkg;

    // Frame symbols
    localparam logic [7:0] SYM_DLE = 8'h10;
    localparam logic [7:0] SYM_DAT = 8'h1A;
    localparam logic [7:0] SYM_NAK = 8'h19;
    localparam logic [7:0] SYM_EOF = 8'h1F;

    // Data field must carry at least this many raw bytes
    localparam logic [7:0] MIN_DATA_LEN = 8'd4;
    // Length byte counts four bytes beyond the data field
    localparam logic [7:0] LEN_OVERHEAD = 8'd4;
    // Number of data slots in one reading
    localparam int         NUM_SLOTS    = 4;

    // Queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    // Parser phase
    typedef enum logic [3:0] {
        PH_HUNT   = 4'd0,
        PH_TYPE   = 4'd1,
        PH_LEN    = 4'd2,
        PH_VER    = 4'd3,
        PH_STAT   = 4'd4,
        PH_DATA   = 4'd5,
        PH_CDLE   = 4'd6,
        PH_EOF    = 4'd7,
        PH_CHK_HI = 4'd8,
        PH_CHK_LO = 4'd9
    } t_phase;

    // Received byte with its symbol class
    typedef struct packed {
        logic [7:0] data;
        logic       is_dle;
        logic       is_dat;
        logic       is_nak;
        logic       is_eof;
        logic       is_zero;
    } t_item;

    // Queue status seen by the front
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

// ===== src/dsfp_front.sv =====
module dsfp_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic [7:0]        i_rx_byte,
    output logic              o_in_stall,
    input  dsfp_pkg::t_q_status i_q_status,
    output logic              o_push,
    output dsfp_pkg::t_item   o_item
);
    import dsfp_pkg::*;

    // Count of bytes taken in, for debug visibility of link activity
    logic [7:0] r_taken;
    logic [7:0] n_taken;

    // Stall only on a full queue; no path from the back side
    assign o_in_stall = i_q_status.full;
    assign o_push     = i_in_valid && !i_q_status.full;

    // Classify the byte once here so the back compares flags only
    always_comb begin
        o_item.data    = i_rx_byte;
        o_item.is_dle  = (i_rx_byte == SYM_DLE);
        o_item.is_dat  = (i_rx_byte == SYM_DAT);
        o_item.is_nak  = (i_rx_byte == SYM_NAK);
        o_item.is_eof  = (i_rx_byte == SYM_EOF);
        o_item.is_zero = (i_rx_byte == 8'h00);
        n_taken        = o_push ? r_taken + 8'd1 : r_taken;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_taken <= '0;
        end else begin
            r_taken <= n_taken;
        end
    end

endmodule

// ===== src/dsfp_queue.sv =====
module dsfp_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  dsfp_pkg::t_item     i_item,
    output dsfp_pkg::t_q_status o_status,
    input  logic                i_pop,
    output logic                o_valid,
    output dsfp_pkg::t_item     o_item
);
    import dsfp_pkg::*;

    t_item           r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wr_ptr;
    logic [Q_AW-1:0] r_rd_ptr;
    logic [Q_AW:0]   r_count;
    logic            do_push;
    logic            do_pop;

    assign do_push        = i_push && !o_status.full;
    assign do_pop         = i_pop && !o_status.empty;
    assign o_status.full  = (r_count == (Q_AW+1)'(Q_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign o_valid        = !o_status.empty;
    assign o_item         = r_mem[r_rd_ptr];

    // Storage, no reset
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== src/dsfp_back.sv =====
module dsfp_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_valid,
    input  dsfp_pkg::t_item i_item,
    output logic            o_pop,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output logic [31:0]     o_reading_bits,
    output logic            o_checksum_error,
    output logic            o_status_error
);
    import dsfp_pkg::*;

    t_phase      r_phase,          n_phase;
    logic        r_nak_seen,       n_nak_seen;
    logic [7:0]  r_data_len,       n_data_len;
    logic        r_field_count,    n_field_count;
    logic        r_status_bad,     n_status_bad;
    logic [7:0]  r_raw_count,      n_raw_count;
    logic [2:0]  r_byte_slot,      n_byte_slot;
    logic        r_escape_pending, n_escape_pending;
    logic [15:0] r_sum_acc,        n_sum_acc;
    logic [7:0]  r_check_high,     n_check_high;
    logic        r_out_valid,      n_out_valid;
    logic [31:0] r_reading_bits;
    logic        r_checksum_error;
    logic        r_status_error;
    logic [7:0]  r_store [NUM_SLOTS];

    logic        produce;
    logic        store_we;
    logic [1:0]  store_idx;
    logic [2:0]  slot_inc;
    logic [7:0]  len_calc;
    logic [31:0] word;
    logic [15:0] rx_sum;

    // Take the next item unless it ends a frame while the result register is held
    assign o_pop = i_q_valid && (r_phase != PH_CHK_LO || !r_out_valid || !i_out_stall);

    assign word     = {r_store[3], r_store[2], r_store[1], r_store[0]};
    assign rx_sum   = {r_check_high, i_item.data};
    assign slot_inc = r_byte_slot + 3'd1;
    assign len_calc = i_item.data - LEN_OVERHEAD;

    // Next state and outputs
    always_comb begin
        n_phase          = r_phase;
        n_nak_seen       = r_nak_seen;
        n_data_len       = r_data_len;
        n_field_count    = r_field_count;
        n_status_bad     = r_status_bad;
        n_raw_count      = r_raw_count;
        n_byte_slot      = r_byte_slot;
        n_escape_pending = r_escape_pending;
        n_sum_acc        = r_sum_acc;
        n_check_high     = r_check_high;
        produce          = 1'b0;
        store_we         = 1'b0;
        store_idx        = r_byte_slot[1:0];
        n_out_valid      = r_out_valid && i_out_stall;

        if (o_pop) begin
            // Running sum adds type byte through EOF; the opening DLE seeds it
            if (r_phase >= PH_TYPE && r_phase <= PH_EOF) begin
                n_sum_acc = r_sum_acc + {8'h00, i_item.data};
            end

            case (r_phase)
                PH_HUNT: begin
                    if (i_item.is_dle) begin
                        n_nak_seen   = 1'b0;
                        n_status_bad = 1'b0;
                        n_sum_acc    = {8'h00, i_item.data};
                        n_phase      = PH_TYPE;
                    end
                end
                PH_TYPE: begin
                    if (i_item.is_dat) begin
                        n_nak_seen = 1'b0;
                        n_phase    = PH_LEN;
                    end else if (i_item.is_nak) begin
                        n_nak_seen = 1'b1;
                        n_phase    = PH_LEN;
                    end else begin
                        n_phase = PH_HUNT;
                    end
                end
                PH_LEN: begin
                    if (r_nak_seen) begin
                        n_phase = PH_HUNT;
                    end else begin
                        n_data_len = len_calc;
                        n_phase    = (len_calc < MIN_DATA_LEN) ? PH_HUNT : PH_VER;
                    end
                end
                PH_VER, PH_STAT: begin
                    if (r_phase == PH_STAT && !i_item.is_zero) begin
                        n_status_bad = 1'b1;
                    end
                    if (!r_field_count) begin
                        n_field_count = 1'b1;
                    end else begin
                        n_field_count = 1'b0;
                        n_phase       = (r_phase == PH_VER) ? PH_STAT : PH_DATA;
                    end
                end
                PH_DATA: begin
                    if ({1'b0, r_raw_count} + 9'd1 < {1'b0, r_data_len}) begin
                        if (!i_item.is_dle || r_escape_pending) begin
                            store_we         = 1'b1;
                            n_escape_pending = 1'b0;
                            n_byte_slot      = slot_inc;
                            n_raw_count      = r_raw_count + 8'd1;
                            // Reading full before the field ended: drop frame
                            if (slot_inc >= 3'(NUM_SLOTS)) begin
                                n_raw_count      = '0;
                                n_byte_slot      = '0;
                                n_escape_pending = 1'b0;
                                n_phase          = PH_HUNT;
                            end
                        end else begin
                            n_escape_pending = 1'b1;
                            n_raw_count      = r_raw_count + 8'd1;
                        end
                    end else begin
                        // Last raw byte is data even if it is a DLE
                        store_we         = 1'b1;
                        n_raw_count      = '0;
                        n_byte_slot      = '0;
                        n_escape_pending = 1'b0;
                        n_phase          = PH_CDLE;
                    end
                end
                PH_CDLE: begin
                    n_phase = i_item.is_dle ? PH_EOF : PH_HUNT;
                end
                PH_EOF: begin
                    n_phase = i_item.is_eof ? PH_CHK_HI : PH_HUNT;
                end
                PH_CHK_HI: begin
                    n_check_high = i_item.data;
                    n_phase      = PH_CHK_LO;
                end
                PH_CHK_LO: begin
                    produce     = 1'b1;
                    n_out_valid = 1'b1;
                    n_phase     = PH_HUNT;
                end
                default: begin
                    n_phase = PH_HUNT;
                end
            endcase
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase          <= PH_HUNT;
            r_nak_seen       <= 1'b0;
            r_data_len       <= '0;
            r_field_count    <= 1'b0;
            r_status_bad     <= 1'b0;
            r_raw_count      <= '0;
            r_byte_slot      <= '0;
            r_escape_pending <= 1'b0;
            r_sum_acc        <= '0;
            r_check_high     <= '0;
            r_out_valid      <= 1'b0;
        end else begin
            r_phase          <= n_phase;
            r_nak_seen       <= n_nak_seen;
            r_data_len       <= n_data_len;
            r_field_count    <= n_field_count;
            r_status_bad     <= n_status_bad;
            r_raw_count      <= n_raw_count;
            r_byte_slot      <= n_byte_slot;
            r_escape_pending <= n_escape_pending;
            r_sum_acc        <= n_sum_acc;
            r_check_high     <= n_check_high;
            r_out_valid      <= n_out_valid;
        end
    end

    // Reading slots, written only by data bytes
    always_ff @(posedge i_clk) begin
        if (store_we) begin
            r_store[store_idx] <= i_item.data;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (produce) begin
            r_reading_bits   <= word;
            r_checksum_error <= (rx_sum != r_sum_acc);
            r_status_error   <= r_status_bad;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_reading_bits   = r_reading_bits;
    assign o_checksum_error = r_checksum_error;
    assign o_status_error   = r_status_error;

endmodule

// ===== src/dle_sensor_frame_parser.sv =====
// Sensor reply frame parser for a DLE-stuffed byte link.
// Input channel: one received byte per item on i_rx_byte, taken at an edge
// where i_in_valid is high and o_in_stall is low.
// Output channel: one item per complete frame on o_reading_bits,
// o_checksum_error and o_status_error, taken at an edge where o_out_valid
// is high and i_out_stall is low. Dropped frames (NAK, bad type, short
// length, reading overflow, bad closing bytes) give no item.
// Throughput: one byte per cycle, sustained, as long as results are taken.
// The classifier front writes a two-entry queue; the parser back reads one
// entry per cycle, unless a held result blocks the low checksum byte, into
// its state machine and a single result register. The result register
// loads at the edge that takes the low checksum byte from the queue.
// A stalled result holds its value; the back keeps parsing bytes that make
// no result, and the queue fills only if a second result is due. The input
// stalls only while the queue is full.
// Reset (synchronous, active low) empties the queue, drops any pending
// result and returns the parser to hunting for DLE.
module dle_sensor_frame_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_rx_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_reading_bits,
    output logic        o_checksum_error,
    output logic        o_status_error
);
    import dsfp_pkg::*;

    t_q_status q_status;
    t_item     push_item;
    t_item     pop_item;
    logic      push;
    logic      pop;
    logic      q_valid;

    dsfp_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_rx_byte  (i_rx_byte),
        .o_in_stall (o_in_stall),
        .i_q_status (q_status),
        .o_push     (push),
        .o_item     (push_item)
    );

    dsfp_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_item   (push_item),
        .o_status (q_status),
        .i_pop    (pop),
        .o_valid  (q_valid),
        .o_item   (pop_item)
    );

    dsfp_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_q_valid        (q_valid),
        .i_item           (pop_item),
        .o_pop            (pop),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_reading_bits   (o_reading_bits),
        .o_checksum_error (o_checksum_error),
        .o_status_error   (o_status_error)
    );

endmodule

// ===== src/dsfp_checker.sv =====
module dsfp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [31:0] o_reading_bits,
    input logic        o_checksum_error,
    input logic        o_status_error
);

    // Reset leaves no result pending and the input open
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("result or stall survived reset");

    // Input stall only rises right after a byte was taken
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_in_stall) |-> $past(i_in_valid))
        else $error("input stall rose without a byte taken");

    // A stalled result stays offered
    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its payload
    a_payload_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            $stable(o_reading_bits) && $stable(o_checksum_error)
            && $stable(o_status_error))
        else $error("result payload changed while stalled");

endmodule

bind dle_sensor_frame_parser dsfp_checker u_dsfp_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in_valid),
    .o_in_stall       (o_in_stall),
    .o_out_valid      (o_out_valid),
    .i_out_stall      (i_out_stall),
    .o_reading_bits   (o_reading_bits),
    .o_checksum_error (o_checksum_error),
    .o_status_error   (o_status_error)
);
